// ===== src/pfr_pkg.sv =====
// Package: shared types, constants and helper functions of the ICMPv6 probe-reply filter.
package pfr_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int BND_W = CNT_W + 1;

  localparam logic [15:0] IDENT_WORD  = 16'hc3d4;
  localparam logic [15:0] SEQ_OFFSET  = 16'd33000;
  localparam int          IP6_HDR_LEN = 40;
  localparam int          PROBE_LEN   = 48;
  localparam int          ICMP_HDR_LEN = 8;
  localparam logic [7:0]  NH_ICMP6    = 8'd58;
  localparam logic [7:0]  NH_HOPOPT   = 8'd0;
  localparam logic [7:0]  NH_ROUTING  = 8'd43;
  localparam logic [7:0]  NH_DSTOPT   = 8'd60;
  localparam logic [7:0]  TYPE_ECHO_REPLY = 8'd129;
  localparam logic [7:0]  TYPE_UNREACH    = 8'd1;
  localparam logic [7:0]  TYPE_TIME_EXC   = 8'd3;

  // match flag bit positions
  localparam int F_VERSION = 0;
  localparam int F_DEST    = 1;
  localparam int F_CHAIN   = 2;
  localparam int F_CODE    = 3;
  localparam int F_IDENT   = 4;
  localparam int F_SEQ     = 5;
  localparam int F_PROBE   = 6;
  localparam int FLAG_W    = 7;

  typedef enum logic [1:0] {
    VERDICT_REJECT  = 2'd0,
    VERDICT_TIME    = 2'd1,
    VERDICT_UNREACH = 2'd2,
    VERDICT_ECHO    = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    REG_OWN_HI    = 3'd0,
    REG_OWN_LO    = 3'd1,
    REG_TGT_HI    = 3'd2,
    REG_TGT_LO    = 3'd3,
    REG_PROBE_SEQ = 3'd4,
    REG_PROBE_CSUM = 3'd5,
    REG_SPARE6    = 3'd6,
    REG_SPARE7    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] own_hi;
    logic [63:0] own_lo;
    logic [63:0] tgt_hi;
    logic [63:0] tgt_lo;
    logic [15:0] probe_seq;
    logic [15:0] probe_csum;
  } cfg_t;

  // per-packet summary handed from the front to the back
  typedef struct packed {
    logic              too_long;
    logic [CNT_W-1:0]  byte_count;
    logic [FLAG_W-1:0] flags;
    logic [15:0]       payload_length;
    logic [CNT_W-1:0]  icmp_start;
    logic [31:0]       checksum_sum;
    logic [15:0]       rx_checksum;
    logic [7:0]        message_type;
    logic [63:0]       src_hi;
    logic [63:0]       src_lo;
  } summary_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [63:0] resp_hi;
    logic [63:0] resp_lo;
  } result_t;

  function automatic logic [7:0] addr_byte(input logic [63:0] hi, input logic [63:0] lo,
                                           input logic [3:0] k);
    logic [63:0] w;
    logic [5:0]  sh;
    w  = k[3] ? lo : hi;
    sh = {3'(3'd7 - k[2:0]), 3'b000};
    return w[sh +: 8];
  endfunction

  function automatic logic [15:0] seq_word(input cfg_t c);
    return c.probe_seq + SEQ_OFFSET;
  endfunction

  // byte i of the probe as it was sent; hop limit is never compared
  function automatic logic [7:0] probe_byte(input cfg_t c, input logic [5:0] i);
    logic [15:0] sw;
    logic [5:0]  k;
    sw = seq_word(c);
    k  = 6'(i - 6'd8);
    priority if (i == 6'd0)  return 8'h60;
    else if (i == 6'd5)      return 8'd8;
    else if (i == 6'd6)      return NH_ICMP6;
    else if (i < 6'd8)       return 8'd0;
    else if (i < 6'd24)      return addr_byte(c.own_hi, c.own_lo, k[3:0]);
    else if (i < 6'd40)      return addr_byte(c.tgt_hi, c.tgt_lo, k[3:0]);
    else if (i == 6'd40)     return 8'd128;
    else if (i == 6'd42)     return c.probe_csum[15:8];
    else if (i == 6'd43)     return c.probe_csum[7:0];
    else if (i == 6'd44)     return IDENT_WORD[15:8];
    else if (i == 6'd45)     return IDENT_WORD[7:0];
    else if (i == 6'd46)     return sw[15:8];
    else if (i == 6'd47)     return sw[7:0];
    else                     return 8'd0;
  endfunction

endpackage

// ===== src/pfr_front.sv =====
// Front end: parses the byte stream and builds one summary per packet.
module pfr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  pfr_pkg::cfg_t       cfg,
  input  logic                byte_valid,
  input  logic [7:0]          data_byte,
  input  logic                last,
  output logic                sum_push,
  output pfr_pkg::summary_t   sum_data
);

  logic [pfr_pkg::CNT_W-1:0]  bc_r, bc_nxt;
  logic [15:0]                plen_r, plen_nxt;
  logic [7:0]                 pnh_r, pnh_nxt;
  logic [pfr_pkg::BND_W-1:0]  bnd_r, bnd_nxt;
  logic [pfr_pkg::CNT_W-1:0]  icmp_r, icmp_nxt;
  logic [31:0]                csum_r, csum_nxt;
  logic [63:0]                srchi_r, srchi_nxt, srclo_r, srclo_nxt;
  logic [7:0]                 mtype_r, mtype_nxt;
  logic [pfr_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  logic [15:0]                rxc_r, rxc_nxt;
  logic                       due_r, due_nxt;
  logic                       tl_r, tl_nxt;

  logic                       proc;
  logic [pfr_pkg::CNT_W-1:0]  pos, rel, k;
  logic [pfr_pkg::BND_W:0]    bnd_sum, bnd_p1;
  logic [15:0]                addend;
  logic                       do_add;
  logic [15:0]                sw;
  logic [5:0]                 pidx;

  always_comb begin
    bc_nxt    = bc_r;
    plen_nxt  = plen_r;
    pnh_nxt   = pnh_r;
    bnd_nxt   = bnd_r;
    icmp_nxt  = icmp_r;
    csum_nxt  = csum_r;
    srchi_nxt = srchi_r;
    srclo_nxt = srclo_r;
    mtype_nxt = mtype_r;
    flags_nxt = flags_r;
    rxc_nxt   = rxc_r;
    due_nxt   = due_r;
    tl_nxt    = tl_r;
    pos       = bc_r;
    proc      = bc_r < pfr_pkg::CNT_W'(pfr_pkg::MAX_FRAME_BYTES);
    k         = pos - pfr_pkg::CNT_W'(24);
    bnd_sum   = {1'b0, bnd_r} + (pfr_pkg::BND_W+1)'(8) + (pfr_pkg::BND_W+1)'({data_byte, 3'b000});
    bnd_p1    = {1'b0, bnd_r} + (pfr_pkg::BND_W+1)'(1);
    addend    = pos[0] ? {8'd0, data_byte} : {data_byte, 8'd0};
    do_add    = 1'b0;
    rel       = '0;
    sw        = pfr_pkg::seq_word(cfg);
    pidx      = '0;

    if (byte_valid) begin
      if (proc) begin
        if (pos == '0 && data_byte[7:4] != 4'd6) flags_nxt[pfr_pkg::F_VERSION] = 1'b0;
        if (pos == pfr_pkg::CNT_W'(4)) plen_nxt = {data_byte, 8'd0};
        if (pos == pfr_pkg::CNT_W'(5)) plen_nxt = plen_r | {8'd0, data_byte};
        if (pos == pfr_pkg::CNT_W'(6)) pnh_nxt = data_byte;
        if (pos >= pfr_pkg::CNT_W'(8) && pos < pfr_pkg::CNT_W'(16))
          srchi_nxt = {srchi_r[55:0], data_byte};
        if (pos >= pfr_pkg::CNT_W'(16) && pos < pfr_pkg::CNT_W'(24))
          srclo_nxt = {srclo_r[55:0], data_byte};
        if (pos >= pfr_pkg::CNT_W'(24) && pos < pfr_pkg::CNT_W'(40) &&
            data_byte != pfr_pkg::addr_byte(cfg.own_hi, cfg.own_lo, k[3:0]))
          flags_nxt[pfr_pkg::F_DEST] = 1'b0;
        if (pos >= pfr_pkg::CNT_W'(8) && pos < pfr_pkg::CNT_W'(40)) do_add = 1'b1;

        // extension header walk
        if (pos >= pfr_pkg::CNT_W'(pfr_pkg::IP6_HDR_LEN) && icmp_r == '0 &&
            flags_r[pfr_pkg::F_CHAIN]) begin
          if (due_r && {2'b00, pos} == bnd_p1) begin
            if (bnd_sum > (pfr_pkg::BND_W+1)'(pfr_pkg::MAX_FRAME_BYTES))
              bnd_nxt = '1;
            else
              bnd_nxt = bnd_sum[pfr_pkg::BND_W-1:0];
            due_nxt = 1'b0;
          end else if (!due_r && {1'b0, pos} == bnd_r) begin
            if (pnh_r == pfr_pkg::NH_HOPOPT || pnh_r == pfr_pkg::NH_ROUTING ||
                pnh_r == pfr_pkg::NH_DSTOPT) begin
              pnh_nxt = data_byte;
              due_nxt = 1'b1;
            end else if (pnh_r == pfr_pkg::NH_ICMP6) begin
              icmp_nxt = pos;
            end else begin
              flags_nxt[pfr_pkg::F_CHAIN] = 1'b0;
            end
          end
        end

        // ICMP part; the start byte itself counts as offset zero
        if (icmp_nxt != '0 && pos >= icmp_nxt) begin
          rel  = pos - icmp_nxt;
          pidx = 6'(rel - pfr_pkg::CNT_W'(pfr_pkg::ICMP_HDR_LEN));
          if (rel == pfr_pkg::CNT_W'(2)) rxc_nxt = {data_byte, 8'd0};
          else if (rel == pfr_pkg::CNT_W'(3)) rxc_nxt = rxc_r | {8'd0, data_byte};
          else do_add = 1'b1;
          if (rel == '0) mtype_nxt = data_byte;
          if (rel == pfr_pkg::CNT_W'(1) && data_byte != 8'd0)
            flags_nxt[pfr_pkg::F_CODE] = 1'b0;
          if (rel == pfr_pkg::CNT_W'(4) && data_byte != pfr_pkg::IDENT_WORD[15:8])
            flags_nxt[pfr_pkg::F_IDENT] = 1'b0;
          if (rel == pfr_pkg::CNT_W'(5) && data_byte != pfr_pkg::IDENT_WORD[7:0])
            flags_nxt[pfr_pkg::F_IDENT] = 1'b0;
          if (rel == pfr_pkg::CNT_W'(6) && data_byte != sw[15:8])
            flags_nxt[pfr_pkg::F_SEQ] = 1'b0;
          if (rel == pfr_pkg::CNT_W'(7) && data_byte != sw[7:0])
            flags_nxt[pfr_pkg::F_SEQ] = 1'b0;
          if (rel >= pfr_pkg::CNT_W'(pfr_pkg::ICMP_HDR_LEN) &&
              rel < pfr_pkg::CNT_W'(pfr_pkg::ICMP_HDR_LEN + pfr_pkg::PROBE_LEN) &&
              pidx != 6'd7 && data_byte != pfr_pkg::probe_byte(cfg, pidx))
            flags_nxt[pfr_pkg::F_PROBE] = 1'b0;
        end

        if (do_add) csum_nxt = csum_r + {16'd0, addend};
        bc_nxt = bc_r + pfr_pkg::CNT_W'(1);
      end else begin
        tl_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    sum_push                = byte_valid && last;
    sum_data.too_long       = tl_nxt;
    sum_data.byte_count     = bc_nxt;
    sum_data.flags          = flags_nxt;
    sum_data.payload_length = plen_nxt;
    sum_data.icmp_start     = icmp_nxt;
    sum_data.checksum_sum   = csum_nxt;
    sum_data.rx_checksum    = rxc_nxt;
    sum_data.message_type   = mtype_nxt;
    sum_data.src_hi         = srchi_nxt;
    sum_data.src_lo         = srclo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || sum_push) begin
      bc_r    <= '0;
      plen_r  <= '0;
      pnh_r   <= '0;
      bnd_r   <= pfr_pkg::BND_W'(pfr_pkg::IP6_HDR_LEN);
      icmp_r  <= '0;
      csum_r  <= '0;
      srchi_r <= '0;
      srclo_r <= '0;
      mtype_r <= '0;
      flags_r <= '1;
      rxc_r   <= '0;
      due_r   <= 1'b0;
      tl_r    <= 1'b0;
    end else begin
      bc_r    <= bc_nxt;
      plen_r  <= plen_nxt;
      pnh_r   <= pnh_nxt;
      bnd_r   <= bnd_nxt;
      icmp_r  <= icmp_nxt;
      csum_r  <= csum_nxt;
      srchi_r <= srchi_nxt;
      srclo_r <= srclo_nxt;
      mtype_r <= mtype_nxt;
      flags_r <= flags_nxt;
      rxc_r   <= rxc_nxt;
      due_r   <= due_nxt;
      tl_r    <= tl_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    sum_push |=> (bc_r == '0 && icmp_r == '0 && !tl_r))
    else $error("packet state not cleared after last byte");
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= pfr_pkg::CNT_W'(pfr_pkg::MAX_FRAME_BYTES))
    else $error("byte count beyond frame limit");
  a_icmp_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    icmp_r == '0 || icmp_r >= pfr_pkg::CNT_W'(pfr_pkg::IP6_HDR_LEN))
    else $error("ICMP start inside IPv6 header");
  a_overlong_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && !last && !proc) |=> tl_r)
    else $error("overlong packet not marked");
`endif

endmodule

// ===== src/pfr_sum_fifo.sv =====
// Two-entry queue of packet summaries between front and back.
module pfr_sum_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfr_pkg::summary_t wdata,
  output logic              full,
  input  logic              pop,
  output pfr_pkg::summary_t rdata,
  output logic              empty
);

  pfr_pkg::summary_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  always_comb begin
    full    = cnt_r == 2'd2;
    empty   = cnt_r == 2'd0;
    do_push = push && !full;
    do_pop  = pop && !empty;
    rdata   = mem_r[rp_r];
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("summary queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) == (wp_r != rp_r))
    else $error("summary queue pointers disagree with count");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !do_pop) |=> full)
    else $error("summary queue lost an entry");
`endif

endmodule

// ===== src/pfr_back.sv =====
// Back end: turns a packet summary into a verdict and queues the result.
module pfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pfr_pkg::cfg_t     cfg,
  input  logic              sum_empty,
  input  pfr_pkg::summary_t sum_data,
  output logic              sum_pop,
  input  logic              res_pop,
  output logic              res_empty,
  output pfr_pkg::result_t  res_data
);

  pfr_pkg::result_t res_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_res_pop;

  pfr_pkg::verdict_t          v;
  pfr_pkg::result_t           res_new;
  logic [pfr_pkg::CNT_W-1:0]  ulen;
  logic [16:0]                tot_len;
  logic [31:0]                sum;
  logic [16:0]                f1, f2;
  logic                       need_ok, csum_ok, type_ok, echo_ok;

  always_comb begin
    ulen    = sum_data.byte_count - sum_data.icmp_start;
    tot_len = {1'b0, sum_data.payload_length} + 17'(pfr_pkg::IP6_HDR_LEN);
    sum     = sum_data.checksum_sum + 32'(ulen) + 32'(pfr_pkg::NH_ICMP6);
    f1      = {1'b0, sum[15:0]} + {1'b0, sum[31:16]};
    f2      = {1'b0, f1[15:0]} + 17'(f1[16]);
    csum_ok = ~f2[15:0] == sum_data.rx_checksum;
    need_ok = sum_data.flags[pfr_pkg::F_VERSION] && sum_data.flags[pfr_pkg::F_DEST] &&
              sum_data.flags[pfr_pkg::F_CHAIN];
    type_ok = sum_data.message_type == pfr_pkg::TYPE_ECHO_REPLY ||
              sum_data.message_type == pfr_pkg::TYPE_UNREACH ||
              sum_data.message_type == pfr_pkg::TYPE_TIME_EXC;
    echo_ok = sum_data.flags[pfr_pkg::F_CODE] && sum_data.flags[pfr_pkg::F_IDENT] &&
              sum_data.flags[pfr_pkg::F_SEQ] && sum_data.src_hi == cfg.tgt_hi &&
              sum_data.src_lo == cfg.tgt_lo;

    priority if (sum_data.too_long ||
                 sum_data.byte_count < pfr_pkg::CNT_W'(pfr_pkg::IP6_HDR_LEN))
      v = pfr_pkg::VERDICT_REJECT;
    else if (!need_ok) v = pfr_pkg::VERDICT_REJECT;
    else if (tot_len != 17'(sum_data.byte_count)) v = pfr_pkg::VERDICT_REJECT;
    else if (sum_data.icmp_start == '0 || ulen < pfr_pkg::CNT_W'(pfr_pkg::ICMP_HDR_LEN))
      v = pfr_pkg::VERDICT_REJECT;
    else if (!type_ok || !csum_ok) v = pfr_pkg::VERDICT_REJECT;
    else if (sum_data.message_type == pfr_pkg::TYPE_ECHO_REPLY)
      v = echo_ok ? pfr_pkg::VERDICT_ECHO : pfr_pkg::VERDICT_REJECT;
    else if (ulen < pfr_pkg::CNT_W'(pfr_pkg::ICMP_HDR_LEN + pfr_pkg::PROBE_LEN) ||
             !sum_data.flags[pfr_pkg::F_PROBE])
      v = pfr_pkg::VERDICT_REJECT;
    else if (sum_data.message_type == pfr_pkg::TYPE_TIME_EXC)
      v = sum_data.flags[pfr_pkg::F_CODE] ? pfr_pkg::VERDICT_TIME : pfr_pkg::VERDICT_REJECT;
    else v = pfr_pkg::VERDICT_UNREACH;

    res_new.verdict = v;
    res_new.resp_hi = (v != pfr_pkg::VERDICT_REJECT) ? sum_data.src_hi : 64'd0;
    res_new.resp_lo = (v != pfr_pkg::VERDICT_REJECT) ? sum_data.src_lo : 64'd0;
  end

  always_comb begin
    res_empty  = cnt_r == 2'd0;
    res_data   = res_r[rp_r];
    sum_pop    = !sum_empty && cnt_r != 2'd2;
    do_res_pop = res_pop && !res_empty;
    wp_nxt     = wp_r ^ sum_pop;
    rp_nxt     = rp_r ^ do_res_pop;
    cnt_nxt    = cnt_r + 2'(sum_pop) - 2'(do_res_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_pop) res_r[wp_r] <= res_new;
  end

`ifndef SYNTHESIS
  a_res_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result queue count out of range");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!res_empty && res_data.verdict == pfr_pkg::VERDICT_REJECT) |->
    (res_data.resp_hi == 64'd0 && res_data.resp_lo == 64'd0))
    else $error("rejected result carries an address");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_pop && !do_res_pop) |=> !res_empty)
    else $error("verdict not queued");
`endif

endmodule

// ===== src/icmpv6_probe_reply_filter.sv =====
// Top level of the ICMPv6 probe-reply filter: config registers and front/back hookup.
// Takes one packet byte per clock, back to back, while the summary queue is not full,
// starting at the IPv6 header. The front end parses each byte in the cycle it is
// accepted; on the byte marked last it hands a packet summary into a two-entry queue,
// and the back end turns a queued summary into a verdict whenever the result queue has
// room. Verdict and responder address wait in a two-entry result queue; push stalls
// whenever the summary queue is full. Registers are 64 bits wide at byte address
// 8*index and must be written while no packet is in flight.
module icmpv6_probe_reply_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_verdict,
  output logic [63:0] out_responder_hi,
  output logic [63:0] out_responder_lo,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  pfr_pkg::cfg_t     cfg_r;
  pfr_pkg::reg_idx_t ridx;
  logic              wr_en;
  logic              byte_valid, sum_push, sum_full, sum_empty, sum_pop;
  pfr_pkg::summary_t sum_in, sum_out;
  pfr_pkg::result_t  res;

  assign pready = 1'b1;
  assign ridx   = pfr_pkg::reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (ridx)
        pfr_pkg::REG_OWN_HI:     cfg_r.own_hi     <= pwdata;
        pfr_pkg::REG_OWN_LO:     cfg_r.own_lo     <= pwdata;
        pfr_pkg::REG_TGT_HI:     cfg_r.tgt_hi     <= pwdata;
        pfr_pkg::REG_TGT_LO:     cfg_r.tgt_lo     <= pwdata;
        pfr_pkg::REG_PROBE_SEQ:  cfg_r.probe_seq  <= pwdata[15:0];
        pfr_pkg::REG_PROBE_CSUM: cfg_r.probe_csum <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      pfr_pkg::REG_OWN_HI:     prdata = cfg_r.own_hi;
      pfr_pkg::REG_OWN_LO:     prdata = cfg_r.own_lo;
      pfr_pkg::REG_TGT_HI:     prdata = cfg_r.tgt_hi;
      pfr_pkg::REG_TGT_LO:     prdata = cfg_r.tgt_lo;
      pfr_pkg::REG_PROBE_SEQ:  prdata = {48'd0, cfg_r.probe_seq};
      pfr_pkg::REG_PROBE_CSUM: prdata = {48'd0, cfg_r.probe_csum};
      default:                 prdata = 64'd0;
    endcase
  end

  assign full       = sum_full;
  assign byte_valid = push && !sum_full;

  pfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .byte_valid(byte_valid),
    .data_byte (in_data_byte),
    .last      (in_last),
    .sum_push  (sum_push),
    .sum_data  (sum_in)
  );

  pfr_sum_fifo u_sum_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (sum_push),
    .wdata(sum_in),
    .full (sum_full),
    .pop  (sum_pop),
    .rdata(sum_out),
    .empty(sum_empty)
  );

  pfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .sum_empty(sum_empty),
    .sum_data (sum_out),
    .sum_pop  (sum_pop),
    .res_pop  (pop),
    .res_empty(empty),
    .res_data (res)
  );

  assign out_verdict      = res.verdict;
  assign out_responder_hi = res.resp_hi;
  assign out_responder_lo = res.resp_lo;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the ICMPv6 probe-reply filter: packet stimulus, byte-level predictor, checker.
`timescale 1ns / 1ps

module tb_top;
  import pfr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        empty;
  logic        pop;
  logic [1:0]  out_verdict;
  logic [63:0] out_responder_hi;
  logic [63:0] out_responder_lo;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  icmpv6_probe_reply_filter DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_data_byte(in_data_byte), .in_last(in_last),
    .empty(empty), .pop(pop), .out_verdict(out_verdict),
    .out_responder_hi(out_responder_hi), .out_responder_lo(out_responder_lo),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // register shadow
  logic [63:0] own_hi, own_lo, tgt_hi, tgt_lo;
  logic [15:0] seq_reg, csum_reg;

  // per-packet parser shadow
  int unsigned pc_cnt, pc_plen, pc_nh, pc_bnd, pc_icmp, pc_sum, pc_rx, pc_type;
  logic [63:0] pc_src [2];
  logic [7:0]  pc_flags;
  bit          pc_len_due, pc_too_long;

  result_t verdicts_due [$];
  int      fail_count;
  int      sender_idle_pct;
  int      sink_stall_pct;
  int      hold_cycles;
  int      cycle_count;
  logic [7:0] pkt [$];

  function automatic logic [7:0] addr_at(logic [63:0] hi, logic [63:0] lo, int k);
    logic [63:0] w;
    w = (k < 8) ? hi : lo;
    return w[(7 - (k % 8)) * 8 +: 8];
  endfunction

  function automatic logic [15:0] seq_sent();
    return seq_reg + SEQ_OFFSET;
  endfunction

  // byte i of the sent echo request
  function automatic logic [7:0] sent_probe_byte(int i);
    logic [15:0] sw;
    sw = seq_sent();
    if (i == 0) return 8'h60;
    if (i == 5) return 8'd8;
    if (i == 6) return NH_ICMP6;
    if (i < 8) return 8'd0;
    if (i < 24) return addr_at(own_hi, own_lo, i - 8);
    if (i < 40) return addr_at(tgt_hi, tgt_lo, i - 24);
    case (i)
      40: return 8'd128;
      42: return csum_reg[15:8];
      43: return csum_reg[7:0];
      44: return IDENT_WORD[15:8];
      45: return IDENT_WORD[7:0];
      46: return sw[15:8];
      47: return sw[7:0];
      default: return 8'd0;
    endcase
  endfunction

  task automatic clear_parse();
    pc_cnt = 0; pc_plen = 0; pc_nh = 0; pc_bnd = IP6_HDR_LEN; pc_icmp = 0;
    pc_sum = 0; pc_rx = 0; pc_type = 0; pc_src[0] = '0; pc_src[1] = '0;
    pc_flags = 8'hff; pc_len_due = 0; pc_too_long = 0;
  endtask

  task automatic parse_byte(logic [7:0] b, int unsigned pos);
    int unsigned k;
    int unsigned rel;
    int unsigned sw;
    sw = seq_sent();
    if (pos == 0 && b[7:4] != 4'd6) pc_flags[F_VERSION] = 1'b0;
    if (pos == 4) pc_plen = b << 8;
    if (pos == 5) pc_plen = pc_plen | b;
    if (pos == 6) pc_nh = b;
    if (pos >= 8 && pos < 24) begin
      k = pos - 8;
      pc_src[k / 8] = {pc_src[k / 8][55:0], b};
    end
    if (pos >= 24 && pos < 40 && b != addr_at(own_hi, own_lo, pos - 24))
      pc_flags[F_DEST] = 1'b0;
    if (pos >= 8 && pos < 40) pc_sum += (pos % 2) ? b : (b << 8);
    if (pos >= IP6_HDR_LEN && pc_icmp == 0 && pc_flags[F_CHAIN]) begin
      if (pc_len_due && pos == pc_bnd + 1) begin
        pc_bnd += 8 + 8 * b;
        pc_len_due = 0;
      end else if (!pc_len_due && pos == pc_bnd) begin
        if (pc_nh == NH_HOPOPT || pc_nh == NH_ROUTING || pc_nh == NH_DSTOPT) begin
          pc_nh = b;
          pc_len_due = 1;
        end else if (pc_nh == NH_ICMP6) begin
          pc_icmp = pos;
        end else begin
          pc_flags[F_CHAIN] = 1'b0;
        end
      end
    end
    if (pc_icmp != 0 && pos >= pc_icmp) begin
      rel = pos - pc_icmp;
      if (rel == 2) pc_rx = b << 8;
      else if (rel == 3) pc_rx = pc_rx | b;
      else pc_sum += (rel % 2) ? b : (b << 8);
      if (rel == 0) pc_type = b;
      if (rel == 1 && b != 0) pc_flags[F_CODE] = 1'b0;
      if (rel == 4 && b != IDENT_WORD[15:8]) pc_flags[F_IDENT] = 1'b0;
      if (rel == 5 && b != IDENT_WORD[7:0]) pc_flags[F_IDENT] = 1'b0;
      if (rel == 6 && b != sw[15:8]) pc_flags[F_SEQ] = 1'b0;
      if (rel == 7 && b != sw[7:0]) pc_flags[F_SEQ] = 1'b0;
      if (rel >= ICMP_HDR_LEN && rel < ICMP_HDR_LEN + PROBE_LEN &&
          rel != ICMP_HDR_LEN + 7 && b != sent_probe_byte(rel - ICMP_HDR_LEN))
        pc_flags[F_PROBE] = 1'b0;
    end
  endtask

  function automatic verdict_t judge_packet();
    int unsigned len, ulen, sum;
    len = pc_cnt;
    if (pc_too_long || len < IP6_HDR_LEN) return VERDICT_REJECT;
    if (!pc_flags[F_VERSION] || !pc_flags[F_DEST] || !pc_flags[F_CHAIN])
      return VERDICT_REJECT;
    if (pc_plen + IP6_HDR_LEN != len) return VERDICT_REJECT;
    if (pc_icmp == 0 || len - pc_icmp < ICMP_HDR_LEN) return VERDICT_REJECT;
    if (pc_type != TYPE_ECHO_REPLY && pc_type != TYPE_UNREACH && pc_type != TYPE_TIME_EXC)
      return VERDICT_REJECT;
    ulen = len - pc_icmp;
    sum = pc_sum + ulen + NH_ICMP6;
    while (sum >> 16) sum = (sum & 32'hffff) + (sum >> 16);
    if ((~sum & 32'hffff) != pc_rx) return VERDICT_REJECT;
    if (pc_type == TYPE_ECHO_REPLY) begin
      if (!pc_flags[F_CODE] || !pc_flags[F_IDENT] || !pc_flags[F_SEQ]) return VERDICT_REJECT;
      if (pc_src[0] != tgt_hi || pc_src[1] != tgt_lo) return VERDICT_REJECT;
      return VERDICT_ECHO;
    end
    if (ulen < ICMP_HDR_LEN + PROBE_LEN || !pc_flags[F_PROBE]) return VERDICT_REJECT;
    if (pc_type == TYPE_TIME_EXC) return pc_flags[F_CODE] ? VERDICT_TIME : VERDICT_REJECT;
    return VERDICT_UNREACH;
  endfunction

  task automatic predict_byte(logic [7:0] b, logic lst);
    result_t r;
    if (pc_cnt >= MAX_FRAME_BYTES) pc_too_long = 1;
    else begin
      parse_byte(b, pc_cnt);
      pc_cnt++;
    end
    if (lst) begin
      r.verdict = judge_packet();
      r.resp_hi = (r.verdict != VERDICT_REJECT) ? pc_src[0] : '0;
      r.resp_lo = (r.verdict != VERDICT_REJECT) ? pc_src[1] : '0;
      verdicts_due.push_back(r);
      clear_parse();
    end
  endtask

  // result checker and receiver
  always @(posedge clk) begin
    result_t e;
    if (rst_n && pop && !empty) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result transaction verdict=%0d", out_verdict);
        fail_count++;
      end else begin
        e = verdicts_due.pop_front();
        if (out_verdict != e.verdict) begin
          $error("verdict: expected %0d, actual %0d", e.verdict, out_verdict);
          fail_count++;
        end
        if (out_responder_hi != e.resp_hi) begin
          $error("responder_hi: expected %h, actual %h", e.resp_hi, out_responder_hi);
          fail_count++;
        end
        if (out_responder_lo != e.resp_lo) begin
          $error("responder_lo: expected %h, actual %h", e.resp_lo, out_responder_lo);
          fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL icmpv6_probe_reply_filter");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic lst);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_last <= lst;
    do @(posedge clk); while (full);
    predict_byte(b, lst);
  endtask

  task automatic go_idle();
    push <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx * 8); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_OWN_HI:     own_hi = val;
      REG_OWN_LO:     own_lo = val;
      REG_TGT_HI:     tgt_hi = val;
      REG_TGT_LO:     tgt_lo = val;
      REG_PROBE_SEQ:  seq_reg = val[15:0];
      REG_PROBE_CSUM: csum_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [63:0] d, logic [63:0] s, logic [63:0] k);
    go_idle();
    write_reg(REG_OWN_HI, a);
    write_reg(REG_OWN_LO, b);
    write_reg(REG_TGT_HI, c);
    write_reg(REG_TGT_LO, d);
    write_reg(REG_PROBE_SEQ, s);
    write_reg(REG_PROBE_CSUM, k);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // kind: 0 echo reply, 1 type 1, 2 type 3, 3 a random type
  task automatic build_pkt(int kind, int n_ext, int extra, logic [7:0] code);
    int ext_nh [$];
    int pos, hl, icmp_off, sum, i;
    logic [15:0] sw, ck;
    pkt.delete();
    for (i = 0; i < n_ext; i++) begin
      case ($urandom_range(2))
        0: ext_nh.push_back(NH_HOPOPT);
        1: ext_nh.push_back(NH_ROUTING);
        default: ext_nh.push_back(NH_DSTOPT);
      endcase
    end
    pkt.push_back(8'h60 | 8'($urandom_range(15)));
    repeat (3) pkt.push_back(8'($urandom));
    pkt.push_back(8'd0); pkt.push_back(8'd0);
    pkt.push_back((n_ext > 0) ? 8'(ext_nh[0]) : NH_ICMP6);
    pkt.push_back(8'($urandom));
    for (i = 0; i < 16; i++)
      pkt.push_back((kind == 0) ? addr_at(tgt_hi, tgt_lo, i) : 8'($urandom));
    for (i = 0; i < 16; i++) pkt.push_back(addr_at(own_hi, own_lo, i));
    for (i = 0; i < n_ext; i++) begin
      hl = $urandom_range(1);
      pkt.push_back((i + 1 < n_ext) ? 8'(ext_nh[i + 1]) : NH_ICMP6);
      pkt.push_back(8'(hl));
      repeat (6 + 8 * hl) pkt.push_back(8'($urandom));
    end
    icmp_off = pkt.size();
    case (kind)
      0: pkt.push_back(TYPE_ECHO_REPLY);
      1: pkt.push_back(TYPE_UNREACH);
      2: pkt.push_back(TYPE_TIME_EXC);
      default: pkt.push_back(8'($urandom));
    endcase
    pkt.push_back(code);
    pkt.push_back(8'd0); pkt.push_back(8'd0);
    if (kind == 0) begin
      sw = seq_sent();
      pkt.push_back(IDENT_WORD[15:8]); pkt.push_back(IDENT_WORD[7:0]);
      pkt.push_back(sw[15:8]); pkt.push_back(sw[7:0]);
    end else begin
      repeat (4) pkt.push_back(8'($urandom));
      for (i = 0; i < PROBE_LEN; i++)
        pkt.push_back((i == 7) ? 8'($urandom) : sent_probe_byte(i));
    end
    repeat (extra) pkt.push_back(8'($urandom));
    pkt[4] = 8'((pkt.size() - 40) >> 8);
    pkt[5] = 8'(pkt.size() - 40);
    sum = 0;
    for (pos = 8; pos < 40; pos++) sum += (pos % 2) ? pkt[pos] : (pkt[pos] << 8);
    for (pos = icmp_off; pos < pkt.size(); pos++)
      sum += ((pos - icmp_off) % 2) ? pkt[pos] : (pkt[pos] << 8);
    sum += (pkt.size() - icmp_off) + NH_ICMP6;
    while (sum >> 16) sum = (sum & 32'hffff) + (sum >> 16);
    ck = ~sum[15:0];
    pkt[icmp_off + 2] = ck[15:8];
    pkt[icmp_off + 3] = ck[7:0];
  endtask

  task automatic send_pkt();
    int i;
    for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic send_noise(int n);
    repeat (n - 1) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // mostly well-formed packets; some damaged, truncated, padded or pure noise
  task automatic random_traffic(int budget);
    int m;
    while (budget > 0) begin
      build_pkt($urandom_range(3) == 3 ? ($urandom_range(3) == 0 ? 3 : $urandom_range(2))
                                       : $urandom_range(2),
                $urandom_range(2), $urandom_range(9),
                ($urandom_range(7) == 0) ? 8'($urandom) : 8'd0);
      m = $urandom_range(9);
      if (m == 0) pkt[$urandom_range(pkt.size() - 1)] ^= 8'(1 << $urandom_range(7));
      else if (m == 1) repeat ($urandom_range(1, 20)) void'(pkt.pop_back());
      else if (m == 2) pkt.push_back(8'($urandom));
      else if (m == 3) begin
        pkt.delete();
        repeat ($urandom_range(1, 50)) pkt.push_back(8'($urandom));
      end
      budget -= pkt.size();
      send_pkt();
    end
  endtask

  task automatic test_reset_values();
    build_pkt(0, 0, 0, 8'd0);
    send_pkt();
    build_pkt(2, 0, 0, 8'd0);
    send_pkt();
  endtask

  task automatic test_directed();
    load_config(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
    build_pkt(0, 0, 3, 8'd0); send_pkt();             // odd ICMP length
    build_pkt(1, 2, 0, 8'd5); send_pkt();             // unreachable, any code
    build_pkt(2, 1, 2, 8'd0); send_pkt();             // time exceeded
    build_pkt(2, 0, 0, 8'd1); send_pkt();             // time exceeded, bad code
    build_pkt(3, 0, 0, 8'd0); send_pkt();             // unsupported type
    build_pkt(0, 0, 0, 8'd0); pkt[pkt.size() - 1] ^= 8'h01; send_pkt();   // checksum/seq off
    build_pkt(0, 0, 0, 8'd0); pkt[0] = 8'h40; send_pkt();                // bad version
    build_pkt(0, 0, 0, 8'd0); pkt[6] = 8'd17; send_pkt();                // wrong next header
    build_pkt(1, 0, 0, 8'd0); repeat (10) void'(pkt.pop_back()); send_pkt(); // cut-off quote
    build_pkt(0, 0, 0, 8'd0); repeat (4) void'(pkt.pop_back()); send_pkt(); // short ICMP
    build_pkt(0, 1, 0, 8'd0); repeat (14) void'(pkt.pop_back()); send_pkt(); // chain runs out
    send_noise(20);                                     // shorter than the IPv6 header
    send_noise(1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_too_long();
    build_pkt(0, 0, 0, 8'd0);
    while (pkt.size() < MAX_FRAME_BYTES + 6) pkt.push_back(8'($urandom));
    send_pkt();
  endtask

  task automatic test_random_phases();
    load_config('0, '0, '0, '0, '0, '0);
    sender_idle_pct = 0; sink_stall_pct = 0;
    random_traffic(200);
    load_config('1, '1, '1, '1, '1, '1);
    sender_idle_pct = 75; sink_stall_pct = 0;
    random_traffic(300);
    load_config(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
    sender_idle_pct = 0; sink_stall_pct = 75;
    random_traffic(300);
    load_config(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
    sender_idle_pct = 17; sink_stall_pct = 17;
    random_traffic(300);
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0; sink_stall_pct = 0;
    hold_cycles = 400;
    repeat (12) send_noise($urandom_range(1, 3));   // fills both queues, push stalls
    go_idle();
    random_traffic(150);
  endtask

  initial begin
    rst_n = 1'b0; push = 1'b0; in_data_byte = '0; in_last = 1'b0; pop = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    own_hi = '0; own_lo = '0; tgt_hi = '0; tgt_lo = '0; seq_reg = '0; csum_reg = '0;
    fail_count = 0; sender_idle_pct = 0; sink_stall_pct = 0; hold_cycles = 0;
    cycle_count = 0;
    clear_parse();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_too_long();
    test_random_phases();
    test_backpressure();
    go_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("PASS icmpv6_probe_reply_filter");
    end else begin
      $display("FAIL icmpv6_probe_reply_filter");
    end
    $finish;
  end

endmodule

// ===== icmpv6_probe_reply_filter.f =====
src/pfr_pkg.sv
src/pfr_front.sv
src/pfr_sum_fifo.sv
src/pfr_back.sv
src/icmpv6_probe_reply_filter.sv
tb/sv/tb_top.sv
